FILE: rtl/mf3_pkg.sv
package mf3_pkg;

  // item kinds on the input side
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // field widths fixed by the interface
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned BL_W     = WIDTH_W + 1;

  // queue between the front and back parts
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // what the back part does with one window column
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } mf3_meta_t;

  localparam int unsigned META_W = $bits(mf3_meta_t);

endpackage

FILE: rtl/mf3_queue.sv
module mf3_queue #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_valid,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic                       pop_valid,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_pop    = pop & (count_r != '0);
  assign do_push   = push_valid & (count_r != CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = count_r;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/mf3_front.sv
module mf3_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_tuser,
  input  logic [mf3_pkg::DATA_W-1:0]       in_tdata,
  // configuration writes
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]        cfg_data,
  // queue side
  input  logic [mf3_pkg::Q_CNT_W-1:0]      q_count,
  output logic                             q_push,
  output mf3_pkg::mf3_meta_t               q_meta,
  output logic [PIXEL_BITS-1:0]            q_lo,
  output logic [PIXEL_BITS-1:0]            q_mid,
  output logic [PIXEL_BITS-1:0]            q_hi,
  output logic [PIXEL_BITS-1:0]            q_near
);

  import mf3_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned PB = PIXEL_BITS;

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
    logic [WIDTH_W-1:0] res;
    res = v;
    if (v < WIDTH_W'(3)) begin
      res = WIDTH_W'(3);
    end else if (int'(v) > int'(MAX_WIDTH)) begin
      res = WIDTH_W'(MAX_WIDTH);
    end
    return res;
  endfunction

  function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
    return (v < HEIGHT_W'(3)) ? HEIGHT_W'(3) : v;
  endfunction

  // line store: one entry per column, near row in the upper half
  logic [2*PB-1:0] line_mem [MAX_WIDTH];
  logic [2*PB-1:0] rd_q_r;

  // frame geometry derived at write time
  logic [WIDTH_W-1:0]  w_m1_r, w_m2_r;
  logic [BL_W-1:0]     w_p1_r;
  logic [HEIGHT_W-1:0] h_m1_r, h_m2_r;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  // stream counters
  logic [WIDTH_W-1:0]  col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic                done_r, done_nxt;
  logic [WIDTH_W-1:0]  ocol_r, ocol_nxt;
  logic [HEIGHT_W-1:0] orow_r, orow_nxt;
  logic [BL_W-1:0]     backlog_r, backlog_nxt;

  // classification of the accepted item
  logic                accept, is_pix, restart, drop, push, emit, wrap;
  logic [WIDTH_W-1:0]  col_use, ocol_base;
  logic [HEIGHT_W-1:0] row_use, orow_base;
  logic [BL_W-1:0]     bl_base;
  logic [PB-1:0]       pix_v;
  mf3_meta_t           meta;

  // read stage
  logic                f1_valid_r;
  logic [AW-1:0]       f1_addr_r;
  logic [PB-1:0]       f1_pix_r;
  mf3_meta_t           f1_meta_r;
  logic                fwd_r;
  logic [2*PB-1:0]     fwd_data_r;
  logic [2*PB-1:0]     rd_data;
  logic [PB-1:0]       rd_near, rd_far;
  logic [AW-1:0]       addr;
  logic [PB-1:0]       a0, b0, a1, b1, a2;

  assign in_tready = ({1'b0, q_count} + {{Q_CNT_W{1'b0}}, f1_valid_r}) < (Q_CNT_W + 1)'(Q_DEPTH);
  assign accept    = in_tvalid & in_tready;

  // item classification and counter updates
  always_comb begin
    is_pix    = (in_tuser == KIND_PIXEL);
    restart   = is_pix & done_r;
    drop      = restart & (backlog_r != w_p1_r);
    col_use   = restart ? '0 : col_r;
    row_use   = restart ? '0 : row_r;
    bl_base   = drop ? '0 : backlog_r;
    ocol_base = drop ? '0 : ocol_r;
    orow_base = drop ? '0 : orow_r;
    push      = is_pix | (done_r & (backlog_r != '0));
    emit      = is_pix ? (bl_base == w_p1_r) : push;
    wrap      = (col_use == w_m1_r);
    pix_v     = is_pix ? PB'(in_tdata) : '0;
    addr      = AW'(col_use);

    meta.emit     = emit;
    meta.interior = (orow_base != '0) && (orow_base <= h_m2_r) &&
                    (ocol_base != '0) && (ocol_base <= w_m2_r);
    meta.last     = (orow_base == h_m1_r) && (ocol_base == w_m1_r);

    col_nxt     = col_r;
    row_nxt     = row_r;
    done_nxt    = done_r;
    ocol_nxt    = ocol_r;
    orow_nxt    = orow_r;
    backlog_nxt = backlog_r;
    if (accept && push) begin
      col_nxt     = wrap ? '0 : col_use + 1'b1;
      row_nxt     = wrap ? row_use + 1'b1 : row_use;
      done_nxt    = (done_r & ~restart) | (wrap & (row_use == h_m1_r));
      backlog_nxt = emit ? bl_base : bl_base + 1'b1;
      ocol_nxt    = ocol_base;
      orow_nxt    = orow_base;
      if (emit) begin
        if (ocol_base == w_m1_r) begin
          ocol_nxt = '0;
          orow_nxt = (orow_base == h_m1_r) ? '0 : orow_base + 1'b1;
        end else begin
          ocol_nxt = ocol_base + 1'b1;
        end
      end
    end
  end

  // geometry written through the configuration port
  always_comb begin
    w_eff = clamp_width(cfg_data[WIDTH_W-1:0]);
    h_eff = clamp_height(cfg_data[HEIGHT_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r    <= clamp_width(WIDTH_W'(1024)) - 1'b1;
      w_m2_r    <= clamp_width(WIDTH_W'(1024)) - WIDTH_W'(2);
      w_p1_r    <= {1'b0, clamp_width(WIDTH_W'(1024))} + 1'b1;
      h_m1_r    <= HEIGHT_W'(1023);
      h_m2_r    <= HEIGHT_W'(1022);
      col_r     <= '0;
      row_r     <= '0;
      done_r    <= 1'b0;
      ocol_r    <= '0;
      orow_r    <= '0;
      backlog_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          w_m1_r <= w_eff - 1'b1;
          w_m2_r <= w_eff - WIDTH_W'(2);
          w_p1_r <= {1'b0, w_eff} + 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          h_m1_r <= h_eff - 1'b1;
          h_m2_r <= h_eff - HEIGHT_W'(2);
        end
        default: begin
        end
      endcase
      col_r     <= '0;
      row_r     <= '0;
      done_r    <= 1'b0;
      ocol_r    <= '0;
      orow_r    <= '0;
      backlog_r <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      done_r    <= done_nxt;
      ocol_r    <= ocol_nxt;
      orow_r    <= orow_nxt;
      backlog_r <= backlog_nxt;
    end
  end

  // read stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= accept & push;
    end
  end

  // read stage payload, with bypass when the same column is read right after its write
  always_ff @(posedge clk) begin
    if (accept && push) begin
      f1_addr_r  <= addr;
      f1_pix_r   <= pix_v;
      f1_meta_r  <= meta;
      fwd_r      <= f1_valid_r && (f1_addr_r == addr);
      fwd_data_r <= {f1_pix_r, rd_near};
    end
  end

  // line store: read at accept, written back in the following cycle
  always_ff @(posedge clk) begin
    if (accept && push) begin
      rd_q_r <= line_mem[addr];
    end
    if (f1_valid_r) begin
      line_mem[f1_addr_r] <= {f1_pix_r, rd_near};
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;
  assign rd_near = rd_data[2*PB-1:PB];
  assign rd_far  = rd_data[PB-1:0];

  // sort the new column (far, near, new) into low, mid, high
  always_comb begin
    a0 = (rd_far < rd_near) ? rd_far : rd_near;
    b0 = (rd_far < rd_near) ? rd_near : rd_far;
    a1 = (b0 < f1_pix_r) ? b0 : f1_pix_r;
    b1 = (b0 < f1_pix_r) ? f1_pix_r : b0;
    a2 = (a0 < a1) ? a0 : a1;
    q_lo  = a2;
    q_mid = (a0 < a1) ? a1 : a0;
    q_hi  = b1;
  end

  assign q_push = f1_valid_r;
  assign q_meta = f1_meta_r;
  assign q_near = rd_near;

endmodule

FILE: rtl/mf3_back.sv
module mf3_back #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // queue side
  input  logic                        q_valid,
  input  mf3_pkg::mf3_meta_t          q_meta,
  input  logic [PIXEL_BITS-1:0]       q_lo,
  input  logic [PIXEL_BITS-1:0]       q_mid,
  input  logic [PIXEL_BITS-1:0]       q_hi,
  input  logic [PIXEL_BITS-1:0]       q_near,
  output logic                        q_pop,
  // result items
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mf3_pkg::DATA_W-1:0]  out_tdata,
  output logic                        out_tlast
);

  import mf3_pkg::*;

  localparam int unsigned PB = PIXEL_BITS;

  function automatic logic [PB-1:0] max3(input logic [PB-1:0] a, b, c);
    logic [PB-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [PB-1:0] min3(input logic [PB-1:0] a, b, c);
    logic [PB-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [PB-1:0] med3(input logic [PB-1:0] a, b, c);
    logic [PB-1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c < lo) ? lo : ((c > hi) ? hi : c);
  endfunction

  // sorted columns of the window: c1 older, c2 newer; c2 keeps its raw near pixel
  logic [PB-1:0] c1_lo_r, c1_mid_r, c1_hi_r;
  logic [PB-1:0] c2_lo_r, c2_mid_r, c2_hi_r, c2_near_r;

  // reduction stage
  logic          s2_valid_r;
  logic [PB-1:0] s2_lo_r, s2_mid_r, s2_hi_r, s2_centre_r;
  logic          s2_interior_r, s2_last_r;

  // output register
  logic          out_valid_r;
  logic [PB-1:0] out_pix_r;
  logic          out_last_r;

  logic          s3_ready, s2_ready;

  assign s3_ready = ~out_valid_r | out_tready;
  assign s2_ready = ~s2_valid_r | s3_ready;
  assign q_pop    = q_valid & (~q_meta.emit | s2_ready);

  // window shift on every popped column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_lo_r   <= '0;
      c1_mid_r  <= '0;
      c1_hi_r   <= '0;
      c2_lo_r   <= '0;
      c2_mid_r  <= '0;
      c2_hi_r   <= '0;
      c2_near_r <= '0;
    end else if (q_pop) begin
      c1_lo_r   <= c2_lo_r;
      c1_mid_r  <= c2_mid_r;
      c1_hi_r   <= c2_hi_r;
      c2_lo_r   <= q_lo;
      c2_mid_r  <= q_mid;
      c2_hi_r   <= q_hi;
      c2_near_r <= q_near;
    end
  end

  // max of lows, median of mids, min of highs over the shifted window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (q_pop && q_meta.emit) begin
      s2_valid_r <= 1'b1;
    end else if (s3_ready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_meta.emit) begin
      s2_lo_r       <= max3(c1_lo_r, c2_lo_r, q_lo);
      s2_mid_r      <= med3(c1_mid_r, c2_mid_r, q_mid);
      s2_hi_r       <= min3(c1_hi_r, c2_hi_r, q_hi);
      s2_centre_r   <= c2_near_r;
      s2_interior_r <= q_meta.interior;
      s2_last_r     <= q_meta.last;
    end
  end

  // final median or border pass-through into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_ready) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      out_pix_r  <= s2_interior_r ? med3(s2_lo_r, s2_mid_r, s2_hi_r) : s2_centre_r;
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_pix_r);
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/median_filter_3x3.sv
// channel  | direction | handshake          | payload
// in_      | input     | in_tvalid/tready   | tdata: pixel_in[7:0]; tuser: kind
// out_     | output    | out_tvalid/tready  | tdata: pixel_out[7:0]; tlast: frame_last
// cfg_     | input     | cfg_we             | cfg_index, cfg_data[15:0]
//
// one item per clock sustained while the queue has room; out_tvalid rises once the item that
// releases a result has passed the read stage, queue, reduction and output register
// the line store is read at accept and written back the following cycle
// rst_n is synchronous; the line store is not cleared, window and counters are
// the front keeps accepting while a result waits, until the four-entry queue and the
// read stage together hold four columns
module median_filter_3x3 #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mf3_pkg::DATA_W-1:0]      in_tdata,   // [7:0] pixel_in
  input  logic                            in_tuser,   // [0] kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mf3_pkg::DATA_W-1:0]      out_tdata,  // [7:0] pixel_out
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]       cfg_data
);

  import mf3_pkg::*;

  localparam int unsigned PB    = PIXEL_BITS;
  localparam int unsigned ENT_W = META_W + 4 * PB;

  logic                q_push, q_pop, q_valid;
  logic [Q_CNT_W-1:0]  q_count;
  mf3_meta_t           f_meta, b_meta;
  logic [PB-1:0]       f_lo, f_mid, f_hi, f_near;
  logic [PB-1:0]       b_lo, b_mid, b_hi, b_near;
  logic [ENT_W-1:0]    q_wdata, q_rdata;

  // front: accept, classify, line store
  mf3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_meta    (f_meta),
    .q_lo      (f_lo),
    .q_mid     (f_mid),
    .q_hi      (f_hi),
    .q_near    (f_near)
  );

  // column queue
  assign q_wdata = {f_meta, f_near, f_hi, f_mid, f_lo};

  mf3_queue #(
    .WIDTH (ENT_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_data  (q_wdata),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_rdata),
    .count      (q_count)
  );

  assign {b_meta, b_near, b_hi, b_mid, b_lo} = q_rdata;

  // back: window, median, output register
  mf3_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_meta     (b_meta),
    .q_lo       (b_lo),
    .q_mid      (b_mid),
    .q_hi       (b_hi),
    .q_near     (b_near),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
